/* src/xrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the helper function of the xoroshiro random source.
package xrs_pkg;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Generator seeding constants
  localparam logic [63:0] SEED_MIX_A = 64'hBD6CB273039BC9C0;
  localparam logic [63:0] SEED_MIX_B = 64'hC7B38377DB5B4910;

  // Single-precision layout
  localparam int          MANT_WIDTH     = 23;
  localparam logic [7:0]  FLOAT_EXP_BASE = 8'd104;  // 127 - 23

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_FLOAT   = 2'd1,
    OP_BOUNDED = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] range;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FLOAT,
    BK_MUL,
    BK_CHECK,
    BK_MOD
  } back_state_t;

  // Bit pattern of m * 2^-23 as an IEEE single, m below 2^23
  function automatic logic [31:0] unit_float_bits(input logic [MANT_WIDTH-1:0] m);
    logic [4:0]            p;
    logic [4:0]            sh;
    logic [MANT_WIDTH-1:0] frac;
    p = '0;
    for (int i = 0; i < MANT_WIDTH; i++) begin
      if (m[i]) p = 5'(i);
    end
    sh   = 5'(MANT_WIDTH) - p;
    frac = m << sh;
    if (m == '0) return 32'd0;
    return {1'b0, FLOAT_EXP_BASE + {3'b000, p}, frac};
  endfunction

endpackage

/* src/xrs_front.sv */
`timescale 1ns / 1ps
// Front end: accepts request items, classifies them and queues commands.
module xrs_front import xrs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] range,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  cmd_t             cmd_in;

  // Classify the request; range only matters for bounded draws
  always_comb begin
    cmd_in.range = '0;
    unique case (op_t'(operation))
      OP_RAW:   cmd_in.op = OP_RAW;
      OP_FLOAT: cmd_in.op = OP_FLOAT;
      OP_BOUNDED: begin
        cmd_in.op    = OP_BOUNDED;
        cmd_in.range = range;
      end
      default: cmd_in.op = OP_NONE;
    endcase
  end

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* src/xrs_mod_unit.sv */
`timescale 1ns / 1ps
// Iterative restoring divider giving (2^32 - range) mod range.
module xrs_mod_unit import xrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [31:0]      dvd;
  logic [31:0]      dvs;
  logic [31:0]      rem;
  logic [32:0]      trial;
  logic [32:0]      diff;

  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= 32'd0 - req.divisor;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= (trial >= {1'b0, dvs}) ? diff[31:0] : trial[31:0];
      dvd <= {dvd[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("divider restarted while busy");

endmodule

/* src/xrs_back.sv */
`timescale 1ns / 1ps
// Back end: generator state, draw sequencer, bounded reduction and result register.
module xrs_back import xrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output mod_req_t    mod_req,
  input  mod_rsp_t    mod_rsp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  back_state_t state, state_next;

  logic [63:0] gen_word_a;
  logic [63:0] gen_word_b;
  logic [63:0] mixed;
  logic [63:0] sum;
  logic [31:0] draw_word;
  logic [63:0] prod;
  logic [31:0] thr;
  logic        thr_ok;

  logic        out_free;
  logic        advance;
  logic        out_load;
  logic [31:0] out_data;
  logic        mul_load;
  logic        thr_load;
  logic        reject_first;
  logic        reject_retry;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign sum       = gen_word_a + gen_word_b;
  assign mixed     = gen_word_a ^ gen_word_b;

  // l < range triggers the threshold computation; l < thr asks for a redraw
  assign reject_first = !thr_ok && (prod[31:0] < cmd.range);
  assign reject_retry = thr_ok && (prod[31:0] < thr);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_FLOAT:   state_next = BK_FLOAT;
            OP_BOUNDED: state_next = BK_MUL;
            default:    state_next = BK_IDLE;
          endcase
        end
      end
      BK_FLOAT: if (out_free) state_next = BK_IDLE;
      BK_MUL:   state_next = BK_CHECK;
      BK_CHECK: begin
        if (reject_first)      state_next = BK_MOD;
        else if (reject_retry) state_next = BK_MUL;
        else if (out_free)     state_next = BK_IDLE;
      end
      BK_MOD:   if (mod_rsp.done) state_next = BK_CHECK;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    advance       = 1'b0;
    out_load      = 1'b0;
    out_data      = '0;
    cmd_pop       = 1'b0;
    mul_load      = 1'b0;
    thr_load      = 1'b0;
    mod_req.start   = 1'b0;
    mod_req.divisor = cmd.range;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_RAW: begin
              if (out_free) begin
                advance  = 1'b1;
                out_load = 1'b1;
                out_data = sum[63:32];
                cmd_pop  = 1'b1;
              end
            end
            OP_FLOAT, OP_BOUNDED: advance = 1'b1;
            default: begin
              if (out_free) begin
                out_load = 1'b1;
                cmd_pop  = 1'b1;
              end
            end
          endcase
        end
      end
      BK_FLOAT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_data = unit_float_bits(draw_word[MANT_WIDTH-1:0]);
          cmd_pop  = 1'b1;
        end
      end
      BK_MUL: mul_load = 1'b1;
      BK_CHECK: begin
        if (reject_first) begin
          mod_req.start = 1'b1;
        end else if (reject_retry) begin
          advance = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          out_data = prod[63:32];
          cmd_pop  = 1'b1;
        end
      end
      BK_MOD: thr_load = mod_rsp.done;
      default: ;
    endcase
  end

  // Generator state: reload on a seed write, step on each draw
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_word_a <= SEED_MIX_A;
      gen_word_b <= SEED_MIX_B;
    end else if (cfg_valid && cfg_ready) begin
      gen_word_a <= cfg_data ^ SEED_MIX_A;
      gen_word_b <= {cfg_data[31:0], cfg_data[63:32]} ^ SEED_MIX_B;
    end else if (advance) begin
      gen_word_a <= {gen_word_a[39:0], gen_word_a[63:40]} ^ mixed ^ {mixed[47:0], 16'd0};
      gen_word_b <= {mixed[26:0], mixed[63:27]};
    end
  end

  always_ff @(posedge clk) begin
    if (advance)  draw_word <= sum[63:32];
    if (mul_load) prod      <= {32'd0, draw_word} * {32'd0, cmd.range};
    if (thr_load) thr       <= mod_rsp.rem;
    if (out_load) value     <= out_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      thr_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop)       thr_ok <= 1'b0;
      else if (thr_load) thr_ok <= 1'b1;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_busy_has_cmd: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> cmd_valid)
    else $error("back end working without a queued command");

  a_thr_below_range: assert property (@(posedge clk) disable iff (rst)
    (thr_ok && state == BK_CHECK) |-> (thr < cmd.range))
    else $error("rejection threshold not below range");

  a_pop_on_result: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> out_valid)
    else $error("command retired without a result");

  a_mod_only_bounded: assert property (@(posedge clk) disable iff (rst)
    mod_req.start |-> (cmd.op == OP_BOUNDED && cmd.range != 32'd0))
    else $error("divider started outside a bounded draw");

endmodule

/* src/xoroshiro_random_source_top.sv */
`timescale 1ns / 1ps
// Top level of the xoroshiro128+ random source.
//
// A xoroshiro128+ generator (rotate/shift 24, 16, 37) serving one request item
// at a time. operation 0 returns the upper 32 bits of the sum of the two
// state words, 1 returns the IEEE single bit pattern of the low 23 bits of a
// draw scaled into [0,1), 2 returns an unbiased integer below range by
// multiply-and-reject (range 0 gives 0 after one draw), and 3 returns 0 without
// touching the state. Items enter a queue of QUEUE_DEPTH commands, so requests
// keep being taken while a result waits on the output. Writing the 64-bit seed
// on the cfg channel reloads both state words; write it only while the block
// is idle. After acceptance an item waits in the queue; the back end then serves
// raw and unused codes straight from its idle state, float draws through the
// float state, and bounded draws through the multiply and check states. A
// bounded draw whose low product word falls below range first runs the 32-step
// restoring divider for the rejection threshold, and each redraw goes back
// through the registered 32x32 multiplier. The back end stalls on a full output
// register and while it waits for the divider.
module xoroshiro_random_source_top import xrs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] range,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Accept and classify requests, hold them until the back end takes them
  xrs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .range     (range),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Rejection threshold for bounded draws
  xrs_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Generator, draw sequencing and the output register
  xrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

endmodule
